### hw/rtl/fmt_pkg.sv
// ----------------------------------------------------------------------------
// fmt_pkg
// types and constants shared by the dual interval timer block
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int SAMPLE_W = 11;

  localparam logic [7:0] ADDR_CNT_A_LO = 8'h24;
  localparam logic [7:0] ADDR_CNT_A_HI = 8'h25;
  localparam logic [7:0] ADDR_VALUE_B  = 8'h26;
  localparam logic [7:0] ADDR_CONTROL  = 8'h27;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // control byte bit positions
  localparam int CTL_LOAD_A   = 0;
  localparam int CTL_LOAD_B   = 1;
  localparam int CTL_ENABLE_A = 2;
  localparam int CTL_ENABLE_B = 3;
  localparam int CTL_CLEAR_A  = 4;
  localparam int CTL_CLEAR_B  = 5;

  localparam int FLAG_A = 0;
  localparam int FLAG_B = 1;

  typedef struct packed {
    logic                mode;
    logic [7:0]          reg_addr;
    logic [7:0]          write_data;
    logic [SAMPLE_W-1:0] sample_count;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status_flags;
    logic       irq_timer_a;
    logic       irq_timer_b;
  } rsp_item_t;

  typedef struct packed {
    logic wr;
    logic adv;
    logic load;
    logic enable;
  } cnt_ctrl_t;

endpackage

### hw/rtl/fm_chip_dual_interval_timer_core.sv
// ----------------------------------------------------------------------------
// fm_chip_dual_interval_timer_core
// timer A and timer B of an fm sound chip, driven by register writes and
// sample-advance items, one result item per input item
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_item_t: mode, reg_addr, write_data, sample_count
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_item_t: status_flags, irq_timer_a, irq_timer_b
//
// one item per cycle sustained while rsp does not stall; an item is held in the input
// register (s1) and its result is then registered into the rsp output register.
// timer state is updated as the item moves from the input register to the result
// register. rst is synchronous and clears the valid bits, control bits, flags and
// counters to zero. while rsp stalls, the input register holds one item and req_ready drops.
// ----------------------------------------------------------------------------
module fm_chip_dual_interval_timer_core
  import fmt_pkg::*;
#(
  parameter int TIMER_A_WIDTH   = 10,
  parameter int PRESCALE_B_BITS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int B_WIDTH = 8 + PRESCALE_B_BITS;

  logic      s1_valid;
  req_item_t s1;
  logic      advance;
  logic      fire;

  logic      load_a;
  logic      enable_a;
  logic      load_b;
  logic      enable_b;
  logic [1:0] flags;
  logic       load_a_next;
  logic       enable_a_next;
  logic       load_b_next;
  logic       enable_b_next;
  logic [1:0] flags_next;

  logic                     is_write;
  logic                     is_adv;
  cnt_ctrl_t                ctrl_a;
  cnt_ctrl_t                ctrl_b;
  logic [TIMER_A_WIDTH-1:0] count_a;
  logic [TIMER_A_WIDTH-1:0] wr_a;
  logic [15:0]              count_a_ext;
  logic [15:0]              merge_a;
  logic [B_WIDTH-1:0]       count_b;
  logic [B_WIDTH-1:0]       wr_b;
  logic                     hit_a;
  logic                     hit_b;
  logic                     irq_a;
  logic                     irq_b;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;
  assign fire      = s1_valid && advance;

  assign is_write = fire && (s1.mode == MODE_WRITE);
  assign is_adv   = fire && (s1.mode == MODE_ADVANCE);

  assign count_a_ext = 16'(count_a);
  always_comb begin
    merge_a = count_a_ext;
    case (s1.reg_addr)
      ADDR_CNT_A_LO: merge_a = {count_a_ext[15:8], s1.write_data};
      ADDR_CNT_A_HI: merge_a = {s1.write_data, count_a_ext[7:0]};
      default:       merge_a = count_a_ext;
    endcase
  end
  assign wr_a = merge_a[TIMER_A_WIDTH-1:0];
  assign wr_b = B_WIDTH'(s1.write_data) << PRESCALE_B_BITS;

  assign ctrl_a = '{
    wr:     is_write && ((s1.reg_addr == ADDR_CNT_A_LO) || (s1.reg_addr == ADDR_CNT_A_HI)),
    adv:    is_adv,
    load:   load_a,
    enable: enable_a
  };
  assign ctrl_b = '{
    wr:     is_write && (s1.reg_addr == ADDR_VALUE_B),
    adv:    is_adv,
    load:   load_b,
    enable: enable_b
  };

  fmt_counter #(
    .WIDTH (TIMER_A_WIDTH)
  ) u_cnt_a (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_a),
    .wr_value (wr_a),
    .n        (s1.sample_count),
    .count    (count_a),
    .hit      (hit_a)
  );

  fmt_counter #(
    .WIDTH (B_WIDTH)
  ) u_cnt_b (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_b),
    .wr_value (wr_b),
    .n        (s1.sample_count),
    .count    (count_b),
    .hit      (hit_b)
  );

  assign irq_a = hit_a && !flags[FLAG_A];
  assign irq_b = hit_b && !flags[FLAG_B];

  always_comb begin
    load_a_next   = load_a;
    enable_a_next = enable_a;
    load_b_next   = load_b;
    enable_b_next = enable_b;
    flags_next    = flags;
    if (is_write && (s1.reg_addr == ADDR_CONTROL)) begin
      load_a_next   = s1.write_data[CTL_LOAD_A];
      load_b_next   = s1.write_data[CTL_LOAD_B];
      enable_a_next = s1.write_data[CTL_ENABLE_A];
      enable_b_next = s1.write_data[CTL_ENABLE_B];
      if (s1.write_data[CTL_CLEAR_A]) begin
        flags_next[FLAG_A] = 1'b0;
      end
      if (s1.write_data[CTL_CLEAR_B]) begin
        flags_next[FLAG_B] = 1'b0;
      end
    end
    if (irq_a) begin
      flags_next[FLAG_A] = 1'b1;
    end
    if (irq_b) begin
      flags_next[FLAG_B] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      load_a    <= 1'b0;
      enable_a  <= 1'b0;
      load_b    <= 1'b0;
      enable_b  <= 1'b0;
      flags     <= '0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
      load_a   <= load_a_next;
      enable_a <= enable_a_next;
      load_b   <= load_b_next;
      enable_b <= enable_b_next;
      flags    <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
    if (fire) begin
      rsp.status_flags <= flags_next;
      rsp.irq_timer_a  <= irq_a;
      rsp.irq_timer_b  <= irq_b;
    end
  end

endmodule

### hw/rtl/fmt_counter.sv
// ----------------------------------------------------------------------------
// fmt_counter
// up-counter of one timer: direct write, advance by a sample count modulo
// its width if loaded, a hit strobe when an enabled advance wraps past the top
// ----------------------------------------------------------------------------
module fmt_counter
  import fmt_pkg::*;
#(
  parameter int WIDTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  cnt_ctrl_t           ctrl,
  input  logic [WIDTH-1:0]    wr_value,
  input  logic [SAMPLE_W-1:0] n,
  output logic [WIDTH-1:0]    count,
  output logic                hit
);

  localparam int SUM_W = ((WIDTH > SAMPLE_W) ? WIDTH : SAMPLE_W) + 1;

  logic [SUM_W-1:0] sum;
  logic [WIDTH-1:0] count_next;

  assign sum = SUM_W'(count) + SUM_W'(n);
  assign hit = ctrl.adv && ctrl.load && ctrl.enable && (sum[SUM_W-1:WIDTH] != '0);

  always_comb begin
    count_next = count;
    if (ctrl.wr) begin
      count_next = wr_value;
    end else if (ctrl.adv && ctrl.load) begin
      count_next = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

### hw/rtl/fmt_checker.sv
// ----------------------------------------------------------------------------
// fmt_checker
// port-level checks of the dual interval timer, bound to the top level
// ----------------------------------------------------------------------------
module fmt_checker
  import fmt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // an interrupt pulse comes with its flag set
  a_irq_a_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.irq_timer_a |-> rsp.status_flags[FLAG_A])
    else $error("irq_timer_a without flag A");

  a_irq_b_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.irq_timer_b |-> rsp.status_flags[FLAG_B])
    else $error("irq_timer_b without flag B");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

endmodule

bind fm_chip_dual_interval_timer_core fmt_checker u_fmt_checker (.*);
